[sv/apph_pkg.sv]
// Package for the all-pass phaser: widths, limits, register codes and
// the elaboration-time builders for the sine and coefficient ROMs.
// No dependencies.
package apph_pkg;

	// sample and datapath widths
	localparam int SMP_W  = 24;
	localparam int SINE_W = 16;
	localparam int COEF_W = 25;
	localparam int OP_W   = 25;
	localparam int PROD_W = 50;

	// gains and limits
	localparam logic [16:0] UNITY      = 17'd65536;
	localparam logic [15:0] FB_MAX     = 16'd62259;
	localparam logic [31:0] LFSR_MASK  = 32'hD000_0001;
	localparam logic [3:0]  NS_RESET   = 4'd4;
	localparam logic [20:0] STEP_RESET = 21'd44739;
	localparam logic [16:0] MIX_RESET  = 17'd32768;

	localparam logic signed [PROD_W-1:0] SMP_HI = PROD_W'((1 << (SMP_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0] SMP_LO = -SMP_HI - PROD_W'(1);

	// constants for the ROM builders
	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_NUM_STAGES  = 3'd0,
		REG_PHASE_STEP  = 3'd1,
		REG_DEPTH       = 3'd2,
		REG_FEEDBACK    = 3'd3,
		REG_MIX         = 3'd4,
		REG_OFFSET_SEED = 3'd5
	} cfg_reg_t;

	// clamp a wide signed value to the sample range
	function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [PROD_W-1:0] v);
		logic signed [SMP_W-1:0] r;
		if (v > SMP_HI) begin
			r = SMP_HI[SMP_W-1:0];
		end else if (v < SMP_LO) begin
			r = SMP_LO[SMP_W-1:0];
		end else begin
			r = v[SMP_W-1:0];
		end
		return r;
	endfunction

	// one step of the right-shifting Galois LFSR
	function automatic logic [31:0] lfsr_next(input logic [31:0] st);
		logic [31:0] r;
		r = st >> 1;
		if (st[0]) begin
			r = r ^ LFSR_MASK;
		end
		return r;
	endfunction

	// unsigned 64-bit quotient by shift and subtract (elaboration only)
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, dvs}) begin
				rem  = rem - {1'b0, dvs};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sine of a 32-bit phase in Q30 by a Taylor polynomial (elaboration only)
	function automatic logic signed [63:0] sin_q30(input logic [31:0] p);
		logic [1:0]  quad;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] xr;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		quad = p[31:30];
		r    = {34'd0, p[29:0]};
		x    = quad[0] ? (Q30_ONE - r) : r;
		xr   = (x * HALF_PI_Q30) >> 30;
		x2   = (xr * xr) >> 30;
		t    = Q30_ONE;
		t    = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
		t    = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
		t    = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
		t    = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
		t    = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
		s    = (xr * t) >> 30;
		if (s > Q30_ONE) begin
			s = Q30_ONE;
		end
		return quad[1] ? -$signed(s) : $signed(s);
	endfunction

	// sine ROM entry k in Q1.15, rounded half away from zero
	function automatic logic signed [SINE_W-1:0] sine_entry(input int k, input int tbits);
		logic signed [63:0] v;
		logic [63:0]        m;
		v = sin_q30(32'(k) << (32 - tbits));
		m = (v < 0) ? 64'(-v) : 64'(v);
		m = (m + 64'd16384) >> 15;
		if (m > 64'd32767) begin
			m = 64'd32767;
		end
		return (v < 0) ? -$signed(m[SINE_W-1:0]) : $signed(m[SINE_W-1:0]);
	endfunction

	// coefficient ROM entry k in Q2.23: -cos(w)/(1+sin(w)) at f = 200 + 7800*k/2^tbits
	function automatic logic signed [COEF_W-1:0] coeff_entry(input int k, input int tbits,
			input int fs);
		logic [63:0]        fnum;
		logic [63:0]        fden;
		logic [63:0]        ph;
		logic signed [63:0] s;
		logic signed [63:0] c;
		logic [63:0]        den;
		logic [63:0]        cm;
		logic [63:0]        mag;
		fnum = (64'd200 << tbits) + 64'd7800 * 64'(k);
		fden = 64'(fs) << tbits;
		ph   = udiv64((fnum << 32) + (fden >> 1), fden);
		if (ph > (64'd1 << 31)) begin
			ph = 64'd1 << 31;
		end
		s    = sin_q30(ph[31:0]);
		c    = sin_q30(32'(ph + Q30_ONE));
		den  = Q30_ONE + 64'(s);
		cm   = (c < 0) ? 64'(-c) : 64'(c);
		mag  = udiv64((cm << 23) + (den >> 1), den);
		return (c > 0) ? -$signed(mag[COEF_W-1:0]) : $signed(mag[COEF_W-1:0]);
	endfunction

endpackage

[sv/apph_rom.sv]
// Sine and all-pass coefficient ROMs with registered reads.
// Contents are built at elaboration from apph_pkg.
module apph_rom import apph_pkg::*; #(
	parameter int SINE_TABLE_BITS  = 10,
	parameter int COEFF_TABLE_BITS = 10,
	parameter int SAMPLE_RATE      = 48000
) (
	input  logic                            clk,
	input  logic [SINE_TABLE_BITS-1:0]      sine_addr,
	input  logic [COEFF_TABLE_BITS:0]       coeff_addr,
	output logic signed [SINE_W-1:0]        sine_data,
	output logic signed [COEF_W-1:0]        coeff_data
);

	localparam int SINE_SIZE  = 1 << SINE_TABLE_BITS;
	localparam int COEFF_SIZE = (1 << COEFF_TABLE_BITS) + 1;
	localparam logic [COEFF_TABLE_BITS:0] COEFF_LAST = (COEFF_TABLE_BITS + 1)'(COEFF_SIZE - 1);

	logic signed [SINE_W-1:0] sine_tbl  [SINE_SIZE];
	logic signed [COEF_W-1:0] coeff_tbl [COEFF_SIZE];

	// build the tables entry by entry
	for (genvar k = 0; k < SINE_SIZE; k++) begin : g_sine
		localparam logic signed [SINE_W-1:0] V = sine_entry(k, SINE_TABLE_BITS);
		assign sine_tbl[k] = V;
	end

	for (genvar k = 0; k < COEFF_SIZE; k++) begin : g_coeff
		localparam logic signed [COEF_W-1:0] V = coeff_entry(k, COEFF_TABLE_BITS, SAMPLE_RATE);
		assign coeff_tbl[k] = V;
	end

	// read both tables every cycle; hold the top entry for addresses past the end
	always_ff @(posedge clk) begin
		sine_data <= sine_tbl[sine_addr];
		if (coeff_addr > COEFF_LAST) begin
			coeff_data <= coeff_tbl[COEFF_LAST];
		end else begin
			coeff_data <= coeff_tbl[coeff_addr];
		end
	end

endmodule

[sv/allpass_phaser_with_lfo.sv]
// Top level of the multistage all-pass phaser with a sine LFO.
// Uses apph_pkg and apph_rom.
//
// Usage:
//   in channel   in_valid / in_stall / in_sample: one signed 24-bit word per
//                sample. The block holds in_stall high while it works on a word.
//   out channel  out_valid / out_stall / out_sample: one phased word per input.
//                The result sits in an output register, so the next input word
//                is taken while a finished result still waits to be taken.
//   cfg channel  cfg_valid / cfg_ready / cfg_index / cfg_data: register writes,
//                always ready. Indexes 0..5: num_stages, phase_step, depth,
//                feedback, mix, offset_seed. Other indexes are dropped.
// Stages: num_stages is clamped to 2..MAX_STAGES active stages. A new word is
//   taken only once the last result has gone to the output register. Each
//   stage needs two products on the one shared 25x25 multiplier plus a ROM
//   read.
// Reset: all history and the LFO phase clear; the per-stage phase offsets
//   are then filled from the LFSR, one per stage, with in_stall high.
//   A write of offset_seed starts the same fill again.
// A stalled output holds its word; the block then waits in its final step.
module allpass_phaser_with_lfo import apph_pkg::*; #(
	parameter int MAX_STAGES       = 12,
	parameter int SAMPLE_RATE      = 48000,
	parameter int SINE_TABLE_BITS  = 10,
	parameter int COEFF_TABLE_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [SMP_W-1:0] in_sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] out_sample,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [31:0]             cfg_data
);

	localparam int STW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam logic [STW-1:0] STAGE_LAST = STW'(MAX_STAGES - 1);
	localparam logic [3:0]     NS_LAST_MAX = 4'(MAX_STAGES - 1);
	localparam int CIW = COEFF_TABLE_BITS + 2;
	localparam logic [CIW-1:0] CIDX_MAX = CIW'(1 << COEFF_TABLE_BITS);
	localparam logic [33:0]    U_BIAS = 34'((64'd1 << 31) + (64'd1 << (31 - COEFF_TABLE_BITS)));
	localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(1 << 15);
	localparam logic signed [PROD_W-1:0] RND23 = PROD_W'(1 << 22);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FB,
		S_FBADD,
		S_DEP,
		S_CIDX,
		S_CMUL,
		S_CSUB,
		S_MIX0,
		S_MIX1,
		S_MIX2,
		S_MIX3
	} state_t;

	// configuration registers
	logic [3:0]  num_stages_q;
	logic [20:0] phase_step_q;
	logic [16:0] depth_q;
	logic [15:0] feedback_q;
	logic [16:0] mix_q;

	// offset fill
	logic            rld_busy_q;
	logic [STW-1:0]  rld_idx_q;
	logic [31:0]     lfsr_q;
	logic [31:0]     lfsr_nxt;
	logic [31:0]     offset_q [MAX_STAGES];

	// sequencer and state
	state_t                   state_q;
	logic [STW-1:0]           stage_q;
	logic [STW-1:0]           stage_nxt;
	logic [3:0]               ns_last;
	logic                     stage_done;
	logic                     out_valid_q;
	logic signed [SMP_W-1:0]  out_sample_q;
	logic [31:0]              lfo_q;
	logic signed [SMP_W-1:0]  last_wet_q;
	logic signed [SMP_W-1:0]  prev_in_q  [MAX_STAGES];
	logic signed [SMP_W-1:0]  prev_out_q [MAX_STAGES];

	// datapath
	logic signed [SMP_W-1:0]  x_q;
	logic signed [SMP_W-1:0]  a_q;
	logic signed [OP_W-1:0]   sum_q;
	logic signed [PROD_W-1:0] fbb_q;
	logic signed [PROD_W-1:0] bias_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [OP_W-1:0]   mul_a;
	logic signed [OP_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] fb_t;
	logic signed [PROD_W-1:0] st_t;
	logic signed [PROD_W-1:0] mx_t;
	logic signed [SMP_W-1:0]  fb_sum;
	logic signed [SMP_W-1:0]  y_stage;
	logic signed [SMP_W-1:0]  mix_out;

	// ROM ports
	logic [STW-1:0]                sine_sel;
	logic [31:0]                   sine_ph;
	logic [33:0]                   u_val;
	logic [CIW-1:0]                cidx_raw;
	logic [COEFF_TABLE_BITS:0]     coeff_addr;
	logic signed [SINE_W-1:0]      sine_data;
	logic signed [COEF_W-1:0]      coeff_data;

	logic cfg_we;
	logic in_take;

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid & cfg_ready;
	assign in_stall   = (state_q != S_IDLE) | rld_busy_q;
	assign in_take    = in_valid & ~in_stall;
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	// write configuration registers, saturating gains on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_stages_q <= NS_RESET;
			phase_step_q <= STEP_RESET;
			depth_q      <= UNITY;
			feedback_q   <= '0;
			mix_q        <= MIX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_STAGES: num_stages_q <= cfg_data[3:0];
				REG_PHASE_STEP: phase_step_q <= cfg_data[20:0];
				REG_DEPTH:      depth_q <= (cfg_data[16:0] > UNITY) ? UNITY : cfg_data[16:0];
				REG_FEEDBACK:   feedback_q <= (cfg_data[15:0] > FB_MAX) ? FB_MAX : cfg_data[15:0];
				REG_MIX:        mix_q <= (cfg_data[16:0] > UNITY) ? UNITY : cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// run the LFSR one step a cycle to fill the stage offsets
	assign lfsr_nxt = lfsr_next(lfsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rld_busy_q <= 1'b1;
			rld_idx_q  <= '0;
			lfsr_q     <= 32'd1;
		end else if (cfg_we && cfg_index == REG_OFFSET_SEED) begin
			rld_busy_q <= 1'b1;
			rld_idx_q  <= '0;
			lfsr_q     <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
		end else if (rld_busy_q) begin
			lfsr_q <= lfsr_nxt;
			if (rld_idx_q == STAGE_LAST) begin
				rld_busy_q <= 1'b0;
			end else begin
				rld_idx_q <= rld_idx_q + STW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rld_busy_q && !(cfg_we && cfg_index == REG_OFFSET_SEED)) begin
			offset_q[rld_idx_q] <= lfsr_nxt;
		end
	end

	// last active stage and next stage index
	always_comb begin
		ns_last = (num_stages_q < 4'd2) ? 4'd1 : (num_stages_q - 4'd1);
		if (ns_last > NS_LAST_MAX) begin
			ns_last = NS_LAST_MAX;
		end
		stage_done = (stage_q == ns_last[STW-1:0]);
		stage_nxt  = (stage_q == STAGE_LAST) ? '0 : (stage_q + STW'(1));
	end

	// address the sine ROM one stage ahead; index the coefficient ROM from u
	always_comb begin
		sine_sel = (state_q == S_CSUB) ? stage_nxt : '0;
		sine_ph  = lfo_q + offset_q[sine_sel];
		u_val    = prod_q[33:0] + U_BIAS;
		cidx_raw = u_val[33 -: CIW];
		if (cidx_raw > CIDX_MAX) begin
			cidx_raw = CIDX_MAX;
		end
		coeff_addr = cidx_raw[COEFF_TABLE_BITS:0];
	end

	apph_rom #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.COEFF_TABLE_BITS(COEFF_TABLE_BITS),
		.SAMPLE_RATE     (SAMPLE_RATE)
	) u_rom (
		.clk       (clk),
		.sine_addr (sine_ph[31 -: SINE_TABLE_BITS]),
		.coeff_addr(coeff_addr),
		.sine_data (sine_data),
		.coeff_data(coeff_data)
	);

	// select multiplier operands for the current step
	always_comb begin
		case (state_q)
			S_FB: begin
				mul_a = OP_W'(last_wet_q);
				mul_b = OP_W'(feedback_q);
			end
			S_DEP: begin
				mul_a = OP_W'(sine_data);
				mul_b = OP_W'(depth_q);
			end
			S_CMUL: begin
				mul_a = coeff_data;
				mul_b = sum_q;
			end
			S_MIX0: begin
				mul_a = OP_W'(x_q);
				mul_b = OP_W'(UNITY - mix_q);
			end
			S_MIX1: begin
				mul_a = OP_W'(a_q);
				mul_b = OP_W'(mix_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half away from zero, fold in the addend, saturate
	always_comb begin
		fb_t    = prod_q + fbb_q - PROD_W'(prod_q[PROD_W-1]);
		st_t    = prod_q + bias_q - PROD_W'(prod_q[PROD_W-1]);
		mx_t    = acc_q + RND16 - PROD_W'(acc_q[PROD_W-1]);
		fb_sum  = sat_smp(fb_t >>> 16);
		y_stage = sat_smp(st_t >>> 23);
		mix_out = sat_smp(mx_t >>> 16);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					x_q   <= in_sample;
					fbb_q <= (PROD_W'(in_sample) <<< 16) + RND16;
				end
			end
			S_FBADD: a_q <= fb_sum;
			S_DEP: begin
				sum_q  <= OP_W'(a_q) + OP_W'(prev_out_q[stage_q]);
				bias_q <= RND23 - (PROD_W'(prev_in_q[stage_q]) <<< 23);
			end
			S_CSUB: a_q <= y_stage;
			S_MIX1: acc_q <= prod_q;
			S_MIX2: acc_q <= acc_q + prod_q;
			default: ;
		endcase
	end

	// sequencer, stage history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			stage_q      <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			lfo_q        <= '0;
			last_wet_q   <= '0;
			for (int i = 0; i < MAX_STAGES; i++) begin
				prev_in_q[i]  <= '0;
				prev_out_q[i] <= '0;
			end
		end else begin
			// drop the word once taken; the final step reloads the register itself
			if (out_valid_q && !out_stall && state_q != S_MIX3) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_FB;
					end
				end
				S_FB:    state_q <= S_FBADD;
				S_FBADD: begin
					stage_q <= '0;
					state_q <= S_DEP;
				end
				S_DEP:   state_q <= S_CIDX;
				S_CIDX:  state_q <= S_CMUL;
				S_CMUL:  state_q <= S_CSUB;
				S_CSUB: begin
					prev_in_q[stage_q]  <= a_q;
					prev_out_q[stage_q] <= y_stage;
					if (stage_done) begin
						state_q <= S_MIX0;
					end else begin
						stage_q <= stage_nxt;
						state_q <= S_DEP;
					end
				end
				S_MIX0:  state_q <= S_MIX1;
				S_MIX1:  state_q <= S_MIX2;
				S_MIX2:  state_q <= S_MIX3;
				S_MIX3: begin
					// hold until the output register is free, then advance the LFO
					if (!out_valid_q || !out_stall) begin
						out_sample_q <= mix_out;
						out_valid_q  <= 1'b1;
						lfo_q        <= lfo_q + 32'(phase_step_q);
						last_wet_q   <= a_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[bench/phaser_monitor.sv]
// Checker for the all-pass phaser: watches the sample, result and register
// channels, predicts every phased word and compares it with the block's output.
// Depends on apph_pkg for widths, gain limits and register codes.
module phaser_monitor import apph_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic signed [SMP_W-1:0] in_sample,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [SMP_W-1:0] out_sample,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [31:0]             cfg_data,
	output int                      errors,
	output int                      pending,
	output int                      n_in,
	output int                      n_out,
	output int                      n_cfg
);

	localparam int MAX_ST    = 12;
	localparam int FS        = 48000;
	localparam int SINE_BITS = 10;
	localparam int COEF_BITS = 10;
	localparam int SHOW_MAX  = 40;

	localparam longint unsigned ONE30       = 64'd1 << 30;
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam longint          S_HI        = (64'sd1 <<< (SMP_W - 1)) - 64'sd1;
	localparam longint          S_LO        = -S_HI - 64'sd1;

	// lookup tables, built once at time zero
	logic signed [SINE_W-1:0] sine_tab [1 << SINE_BITS];
	logic signed [COEF_W-1:0] coef_tab [(1 << COEF_BITS) + 1];

	// register copies
	logic [3:0]  ns;
	logic [20:0] step;
	logic [16:0] dep;
	logic [15:0] fbk;
	logic [16:0] wet;
	logic [31:0] seed;

	// filter and LFO state
	logic [31:0]             lfo_ph;
	logic [31:0]             offs     [MAX_ST];
	logic signed [SMP_W-1:0] hist_in  [MAX_ST];
	logic signed [SMP_W-1:0] hist_out [MAX_ST];
	logic signed [SMP_W-1:0] last_wet;

	// phased words still owed by the block, oldest first
	logic signed [SMP_W-1:0] phased_q [$];
	int                      shown;

	// sine of a 32-bit phase in Q30, Taylor series on the first quadrant
	function automatic longint taylor_sin(input logic [31:0] p);
		longint unsigned x;
		longint unsigned xr;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		x  = p[30] ? (ONE30 - {34'd0, p[29:0]}) : {34'd0, p[29:0]};
		xr = (x * PI_HALF_Q30) >> 30;
		x2 = (xr * xr) >> 30;
		t  = ONE30;
		t  = ONE30 - (((x2 * t) >> 30) / 64'd110);
		t  = ONE30 - (((x2 * t) >> 30) / 64'd72);
		t  = ONE30 - (((x2 * t) >> 30) / 64'd42);
		t  = ONE30 - (((x2 * t) >> 30) / 64'd20);
		t  = ONE30 - (((x2 * t) >> 30) / 64'd6);
		s  = (xr * t) >> 30;
		if (s > ONE30) begin
			s = ONE30;
		end
		return p[31] ? -$signed(s) : $signed(s);
	endfunction

	// shift right with rounding half away from zero
	function automatic longint rnd_shift(input longint v, input int n);
		longint half;
		half = 64'sd1 <<< (n - 1);
		if (v >= 0) begin
			return (v + half) >>> n;
		end
		return -((-v + half) >>> n);
	endfunction

	function automatic logic signed [SMP_W-1:0] clip(input longint v);
		if (v > S_HI) begin
			return S_HI[SMP_W-1:0];
		end else if (v < S_LO) begin
			return S_LO[SMP_W-1:0];
		end
		return v[SMP_W-1:0];
	endfunction

	// refill the per-stage phase offsets from a seed, zero acts as one
	function automatic void load_offsets(input logic [31:0] sd);
		logic [31:0] st;
		st = (sd == 32'd0) ? 32'd1 : sd;
		for (int i = 0; i < MAX_ST; i++) begin
			st = st[0] ? ((st >> 1) ^ LFSR_MASK) : (st >> 1);
			offs[i] = st;
		end
	endfunction

	// run one sample through feedback, the active stages and the dry/wet mix
	function automatic logic signed [SMP_W-1:0] phase_sample(input logic signed [SMP_W-1:0] x);
		longint                  fbg;
		longint                  dg;
		longint                  mg;
		longint                  acc;
		longint                  lv;
		longint                  u;
		longint                  ci;
		longint                  cf;
		logic signed [SMP_W-1:0] y;
		logic [31:0]             ph;
		int                      n;
		fbg = (fbk > FB_MAX) ? FB_MAX : fbk;
		dg  = (dep > UNITY) ? UNITY : dep;
		mg  = (wet > UNITY) ? UNITY : wet;
		n   = (ns < 2) ? 2 : ((ns > MAX_ST) ? MAX_ST : ns);
		acc = clip(longint'(x) + rnd_shift(longint'(last_wet) * fbg, 16));
		for (int s = 0; s < n; s++) begin
			ph = lfo_ph + offs[s];
			lv = sine_tab[ph[31:32-SINE_BITS]];
			u  = (64'sd1 <<< 31) + lv * dg;
			ci = (u + (64'sd1 <<< (31 - COEF_BITS))) >>> (32 - COEF_BITS);
			if (ci > (1 << COEF_BITS)) begin
				ci = 1 << COEF_BITS;
			end
			cf = coef_tab[ci];
			y  = clip(rnd_shift(cf * (acc + hist_out[s]), 23) - hist_in[s]);
			hist_in[s]  = acc[SMP_W-1:0];
			hist_out[s] = y;
			acc         = y;
		end
		last_wet = acc[SMP_W-1:0];
		lfo_ph   = lfo_ph + step;
		return clip(rnd_shift(longint'(x) * (longint'(UNITY) - mg) + acc * mg, 16));
	endfunction

	// build the sine table and the coefficient table over 200..8000 Hz
	initial begin
		longint          v;
		longint unsigned m;
		longint unsigned fnum;
		longint unsigned fden;
		longint unsigned ang;
		longint          sn;
		longint          cs;
		longint unsigned den;
		longint unsigned cm;
		longint unsigned mag;
		for (int k = 0; k < (1 << SINE_BITS); k++) begin
			v = taylor_sin(32'(k) << (32 - SINE_BITS));
			m = (v < 0) ? -v : v;
			m = (m + 64'd16384) >> 15;
			if (m > 64'd32767) begin
				m = 64'd32767;
			end
			sine_tab[k] = SINE_W'((v < 0) ? -longint'(m) : longint'(m));
		end
		for (int k = 0; k <= (1 << COEF_BITS); k++) begin
			fnum = (64'd200 << COEF_BITS) + 64'd7800 * 64'(k);
			fden = 64'(FS) << COEF_BITS;
			ang  = ((fnum << 32) + (fden >> 1)) / fden;
			if (ang > (64'd1 << 31)) begin
				ang = 64'd1 << 31;
			end
			sn  = taylor_sin(ang[31:0]);
			cs  = taylor_sin(32'(ang + ONE30));
			den = ONE30 + sn;
			cm  = (cs < 0) ? -cs : cs;
			mag = ((cm << 23) + (den >> 1)) / den;
			coef_tab[k] = COEF_W'((cs > 0) ? -longint'(mag) : longint'(mag));
		end
	end

	// track the channels: check results first, then register writes, then new words
	always @(posedge clk or negedge arst_n) begin
		logic signed [SMP_W-1:0] want;
		if (!arst_n) begin
			ns     = NS_RESET;
			step   = STEP_RESET;
			dep    = UNITY;
			fbk    = '0;
			wet    = MIX_RESET;
			seed   = 32'd1;
			lfo_ph = '0;
			for (int i = 0; i < MAX_ST; i++) begin
				hist_in[i]  = '0;
				hist_out[i] = '0;
			end
			last_wet = '0;
			load_offsets(seed);
			phased_q.delete();
			errors  = 0;
			shown   = 0;
			n_in    = 0;
			n_out   = 0;
			n_cfg   = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_out++;
				if (phased_q.size() == 0) begin
					errors++;
					if (shown < SHOW_MAX) begin
						shown++;
						$error("out_sample: expected none waiting, actual %0d", out_sample);
					end
				end else begin
					want = phased_q.pop_front();
					if (out_sample !== want) begin
						errors++;
						if (shown < SHOW_MAX) begin
							shown++;
							$error("out_sample: expected %0d, actual %0d", want, out_sample);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				n_cfg++;
				case (cfg_reg_t'(cfg_index))
					REG_NUM_STAGES: ns = cfg_data[3:0];
					REG_PHASE_STEP: step = cfg_data[20:0];
					REG_DEPTH: dep = cfg_data[16:0];
					REG_FEEDBACK: fbk = cfg_data[15:0];
					REG_MIX: wet = cfg_data[16:0];
					REG_OFFSET_SEED: begin
						seed = cfg_data;
						load_offsets(seed);
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				n_in++;
				phased_q.push_back(phase_sample(in_sample));
			end
			pending <= phased_q.size();
		end
	end

endmodule

[bench/tb_allpass_phaser_with_lfo.sv]
// Regression bench for the all-pass phaser: drives samples and register
// writes under random idling and gives the verdict.
// Depends on apph_pkg, allpass_phaser_with_lfo and phaser_monitor.
module tb_allpass_phaser_with_lfo;
	import apph_pkg::*;

	localparam int RAND_PHASES    = 10;
	localparam int PHASE_ITEMS    = 58;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF       = 400;

	// indexes that map to no register
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	localparam logic signed [SMP_W-1:0] S_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] S_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [SMP_W-1:0] in_sample;
	logic out_valid;
	logic out_stall;
	logic signed [SMP_W-1:0] out_sample;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	int errors;
	int pending;
	int n_in;
	int n_out;
	int n_cfg;
	int send_idle     = 9;
	int recv_idle     = 45;
	int hold_cycles   = 0;
	int settings_used = 0;
	int quiet         = 0;

	always #6 clk = ~clk;

	allpass_phaser_with_lfo u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	phaser_monitor u_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending),
		.n_in       (n_in),
		.n_out      (n_out),
		.n_cfg      (n_cfg)
	);

	// offer one sample word, with a random gap first, and hold it until taken
	task automatic push_sample(input logic signed [SMP_W-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_sample <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// write one register; valid stays up for a following write
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [3:0] ns, input logic [20:0] step,
			input logic [16:0] dep, input logic [15:0] fbk, input logic [16:0] wet,
			input logic [31:0] seed);
		write_reg(REG_NUM_STAGES, 32'(ns));
		write_reg(REG_PHASE_STEP, 32'(step));
		write_reg(REG_DEPTH, 32'(dep));
		write_reg(REG_FEEDBACK, 32'(fbk));
		write_reg(REG_MIX, 32'(wet));
		write_reg(REG_OFFSET_SEED, seed);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// drop valid and wait until every phased word has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// mostly full-range words, some rail values and some near zero
	function automatic logic signed [SMP_W-1:0] pick_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3: return SMP_W'(int'($urandom_range(512)) - 256);
			default: return r[SMP_W-1:0];
		endcase
	endfunction

	// receiver: random stall, or one long hold-off when asked
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	// watchdog: end the run after a long stretch with no word moving
	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// reset settings: rails, zero, unit steps, alternating bit patterns
		settings_used++;
		push_sample(S_MAX);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample(S_MIN);
		push_sample('0);
		push_sample(24'sd1);
		push_sample(-24'sd1);
		push_sample(24'h555555);
		push_sample(24'hAAAAAA);

		// spare indexes, stage count below range, gains past saturation, zero seed
		settle();
		write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_7, 32'h1234_5678);
		apply_settings(4'd0, 21'd1789570, 17'h1FFFF, 16'hFFFF, 17'h1FFFF, 32'd0);
		push_sample(S_MAX);
		push_sample(S_MAX);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample(S_MIN);
		push_sample('0);

		// stage count above range, no depth, no feedback, dry only
		settle();
		apply_settings(4'd15, 21'd895, 17'd0, 16'd0, 17'd0, 32'hFFFF_FFFF);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample(24'sd1);
		push_sample(-24'sd1);

		// full wet at the feedback limit, widest phase step
		settle();
		apply_settings(4'd13, 21'h1FFFFF, UNITY, FB_MAX, UNITY, 32'h8000_0000);
		push_sample(S_MIN);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample(S_MAX);
		push_sample('0);

		// random phases: lowest settings, highest settings, then random ones
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 4) begin
				send_idle = 45;
				recv_idle = 9;
			end
			if (p == 7) begin
				send_idle = 0;
				recv_idle = 0;
			end
			settle();
			if (p == 0) begin
				apply_settings(4'd2, 21'd895, 17'd0, 16'd0, 17'd0, 32'd1);
			end else if (p == 1) begin
				apply_settings(4'd12, 21'd1789570, UNITY, FB_MAX, UNITY, 32'hFFFF_FFFF);
			end else begin
				apply_settings(4'($urandom_range(15)), 21'($urandom),
					($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(65536)),
					($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(62259)),
					($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(65536)),
					$urandom);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the output off while words keep coming, so the input backs up
				if (p == 8 && i == 10) begin
					hold_cycles = HOLD_OFF;
				end
				push_sample(pick_sample());
			end
		end

		// drain and let the pipeline run dry
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("Phaser run: %0d samples in, %0d phased words checked, %0d register writes, %0d settings",
			n_in, n_out, n_cfg, settings_used);
		$display("Covered stage clamps, saturated gains, zero seed, spare indexes and a long output hold-off");
		if (errors == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
